### rtl/spac_pkg.sv
// ----------------------------------------------------------------------------
// spac_pkg: shared types and constants for the sweep-and-prune collision block
// Entity record layout, opcodes, result kinds and the result record.
// ----------------------------------------------------------------------------
package spac_pkg;

  localparam int unsigned MaxEntities = 8;
  localparam int unsigned IdxW = 3;
  localparam int unsigned CntW = 4;
  localparam int unsigned EventCap = 28;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpRun    = 2'd2;
  localparam logic [1:0] OpRead   = 2'd3;

  localparam logic [1:0] KindEvent = 2'd0;
  localparam logic [1:0] KindRead  = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  off_x;
    logic [7:0]  off_y;
    logic [7:0]  width;
    logic [7:0]  height;
    logic        is_static;
    logic        is_trigger;
    logic [7:0]  layer_bits;
    logic [7:0]  interact_bits;
  } entity_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  first_entity;
    logic [2:0]  second_entity;
    logic [14:0] pen;
    logic [1:0]  normal_x;
    logic [1:0]  normal_y;
    logic [15:0] read_x;
    logic [15:0] read_y;
    logic        last_item;
  } result_t;

  // memory port bundle between engine and table
  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    entity_t         wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

### rtl/spac_table.sv
// ----------------------------------------------------------------------------
// spac_table: entity record memory
// One write port and one synchronous read port; read data is registered.
// ----------------------------------------------------------------------------
module spac_table (
  input  logic              clk_i,
  input  spac_pkg::mem_req_t req_i,
  output spac_pkg::entity_t rdata_o
);

  spac_pkg::entity_t mem_q [spac_pkg::MaxEntities];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

### rtl/spac_engine.sv
// ----------------------------------------------------------------------------
// spac_engine: command sequencer
// Loads, removes and reads entries; runs the sort and the pair sweep through
// the entity memory, one memory access per cycle.
// ----------------------------------------------------------------------------
module spac_engine (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               opcode_i,
  input  logic [2:0]               index_i,
  input  spac_pkg::entity_t        ent_i,
  input  logic [3:0]               count_i,
  output spac_pkg::mem_req_t       mem_o,
  input  spac_pkg::entity_t        mem_rdata_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output spac_pkg::result_t        res_o
);

  localparam int unsigned IW = spac_pkg::IdxW;
  localparam int unsigned CW = spac_pkg::CntW;
  localparam int unsigned N  = spac_pkg::MaxEntities;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_COLLECT, S_SORT_RD, S_SORT_CMP, S_PAIR_A, S_PAIR_B,
    S_PAIR_WAIT, S_TEST, S_PUSH_A, S_PUSH_B, S_EMIT, S_DONE, S_OUT
  } state_e;

  state_e             state_q;
  logic [N-1:0]       valid_q;
  logic [IW-1:0]      order_q [N];
  logic [15:0]        keyx_q [N];
  logic [CW-1:0]      act_q;
  logic [CW-1:0]      i_q, j_q, scan_q;
  logic [IW-1:0]      idx_q;
  logic [5:0]         nev_q;
  spac_pkg::entity_t  ea_q, eb_q;
  spac_pkg::result_t  res_q, res_d;
  logic               rv_q;
  state_e             after_q;
  logic               hit_q;
  logic [14:0]        pen_q;
  logic [1:0]         nx_q, ny_q;
  logic               out_free, res_load;

  // geometry on registered A/B records
  logic signed [19:0] ha, va, hb, vb, cax, cay, cbx, cby, dx, dy, ox, oy, adx, ady;
  logic signed [11:0] ia, ib;
  logic               skip, prune;
  always_comb begin
    ha  = 20'(ea_q.width) <<< 5;
    va  = 20'(ea_q.height) <<< 5;
    hb  = 20'(eb_q.width) <<< 5;
    vb  = 20'(eb_q.height) <<< 5;
    cax = 20'(signed'(ea_q.pos_x)) + (20'(signed'(ea_q.off_x)) <<< 6) + ha;
    cay = 20'(signed'(ea_q.pos_y)) + (20'(signed'(ea_q.off_y)) <<< 6) + va;
    cbx = 20'(signed'(eb_q.pos_x)) + (20'(signed'(eb_q.off_x)) <<< 6) + hb;
    cby = 20'(signed'(eb_q.pos_y)) + (20'(signed'(eb_q.off_y)) <<< 6) + vb;
    dx  = cbx - cax;
    dy  = cby - cay;
    adx = dx[19] ? -dx : dx;
    ady = dy[19] ? -dy : dy;
    ox  = ha + hb - adx;
    oy  = va + vb - ady;
    skip = (ea_q.is_static && eb_q.is_static) ||
           ((ea_q.layer_bits & eb_q.interact_bits) == 8'd0) ||
           ((eb_q.layer_bits & ea_q.interact_bits) == 8'd0);
    ia = 12'(signed'(ea_q.pos_x[15:6])) + 12'(signed'(ea_q.off_x)) + 12'(ea_q.width);
    ib = 12'(signed'(eb_q.pos_x[15:6]));
    prune = ib > ia;
  end

  // insertion sort done as bubble passes: compare slot scan-1 and scan
  logic swap;
  assign swap = $signed(keyx_q[scan_q[IW-1:0]-IW'(1)]) > $signed(keyx_q[scan_q[IW-1:0]]);

  logic [CW-1:0] cnt_sat;
  assign cnt_sat = (count_i > CW'(N)) ? CW'(N) : count_i;

  // pushed values: positions kept at 16 bits (wrap)
  logic signed [17:0] amt_a, amt_b;
  logic [14:0] half;
  always_comb begin
    half = pen_q >> 1;
    if (eb_q.is_static) begin
      amt_a = 18'(pen_q); amt_b = '0;
    end else if (ea_q.is_static) begin
      amt_a = '0; amt_b = 18'(pen_q);
    end else begin
      amt_a = 18'(half); amt_b = 18'(half);
    end
  end

  always_comb begin
    mem_o = '0;
    case (state_q)
      S_IDLE: begin
        mem_o.raddr = index_i;
        mem_o.we    = in_valid_i && in_ready_o && opcode_i == spac_pkg::OpLoad;
        mem_o.waddr = index_i;
        mem_o.wdata = ent_i;
      end
      // hold the address so the readback stays put while the output stalls
      S_READ:    mem_o.raddr = idx_q;
      S_SORT_RD: mem_o.raddr = order_q[scan_q[IW-1:0]];
      S_PAIR_A:  mem_o.raddr = order_q[i_q[IW-1:0]];
      S_PAIR_B:  mem_o.raddr = order_q[j_q[IW-1:0]];
      S_PUSH_A: begin
        mem_o.we = 1'b1;
        mem_o.waddr = order_q[i_q[IW-1:0]];
        mem_o.wdata = ea_q;
        mem_o.wdata.pos_x = ea_q.pos_x - 16'(signed'(nx_q)) * 16'(amt_a);
        mem_o.wdata.pos_y = ea_q.pos_y - 16'(signed'(ny_q)) * 16'(amt_a);
      end
      S_PUSH_B: begin
        mem_o.we = 1'b1;
        mem_o.waddr = order_q[j_q[IW-1:0]];
        mem_o.wdata = eb_q;
        mem_o.wdata.pos_x = eb_q.pos_x + 16'(signed'(nx_q)) * 16'(amt_b);
        mem_o.wdata.pos_y = eb_q.pos_y + 16'(signed'(ny_q)) * 16'(amt_b);
      end
      default: ;
    endcase
  end

  // next result item
  always_comb begin
    res_d = '0;
    case (state_q)
      S_READ: begin
        res_d.kind         = spac_pkg::KindRead;
        res_d.first_entity = idx_q;
        res_d.read_x       = mem_rdata_i.pos_x;
        res_d.read_y       = mem_rdata_i.pos_y;
        res_d.last_item    = 1'b1;
      end
      S_EMIT: begin
        res_d.kind          = spac_pkg::KindEvent;
        res_d.first_entity  = order_q[i_q[IW-1:0]];
        res_d.second_entity = order_q[j_q[IW-1:0]];
        res_d.pen           = pen_q;
        res_d.normal_x      = nx_q;
        res_d.normal_y      = ny_q;
      end
      S_DONE: begin
        res_d.kind      = spac_pkg::KindDone;
        res_d.last_item = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_free = !rv_q || res_ready_i;
  assign res_load = out_free &&
                    (state_q == S_READ || state_q == S_DONE ||
                     (state_q == S_EMIT && hit_q && nev_q < 6'(spac_pkg::EventCap)));

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      act_q   <= '0;
      rv_q    <= 1'b0;
      res_q   <= '0;
      hit_q   <= 1'b0;
      i_q <= '0; j_q <= '0; scan_q <= '0; nev_q <= '0; idx_q <= '0;
      after_q <= S_IDLE;
    end else begin
      if (res_load) begin
        rv_q  <= 1'b1;
        res_q <= res_d;
      end else if (res_ready_i) begin
        rv_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i && in_ready_o) begin
          idx_q <= index_i;
          case (opcode_i)
            spac_pkg::OpLoad:   valid_q[index_i] <= 1'b1;
            spac_pkg::OpRemove: valid_q[index_i] <= 1'b0;
            spac_pkg::OpRead:   state_q <= S_READ;
            spac_pkg::OpRun: begin
              act_q <= '0; scan_q <= '0; nev_q <= '0;
              state_q <= S_COLLECT;
            end
            default: ;
          endcase
        end
        S_READ: if (out_free) state_q <= S_IDLE;
        S_COLLECT: begin
          if (scan_q >= cnt_sat) begin
            scan_q <= CW'(1);
            i_q <= CW'(1);
            j_q <= '0;
            state_q <= (act_q >= CW'(2)) ? S_SORT_RD : S_DONE;
          end else begin
            if (valid_q[scan_q[IW-1:0]]) begin
              order_q[act_q[IW-1:0]] <= scan_q[IW-1:0];
              act_q <= act_q + CW'(1);
            end
            scan_q <= scan_q + CW'(1);
          end
        end
        // load key x of slot scan into keyx (one read per slot)
        S_SORT_RD: state_q <= S_SORT_CMP;
        S_SORT_CMP: begin
          // first visit of slot scan captures its x; slot 0 captured too
          if (i_q != CW'(0)) begin
            keyx_q[scan_q[IW-1:0]] <= mem_rdata_i.pos_x;
            i_q <= CW'(0);
            if (scan_q == CW'(1)) begin
              // need slot 0 too: fetch it through the read port
              scan_q <= CW'(0);
              after_q <= S_SORT_RD;
              state_q <= S_SORT_RD;
            end
          end else if (after_q == S_SORT_RD) begin
            keyx_q[0] <= mem_rdata_i.pos_x;
            after_q <= S_IDLE;
            scan_q <= CW'(1);
          end else if (scan_q != CW'(0) && swap) begin
            keyx_q[scan_q[IW-1:0]] <= keyx_q[scan_q[IW-1:0]-IW'(1)];
            keyx_q[scan_q[IW-1:0]-IW'(1)] <= keyx_q[scan_q[IW-1:0]];
            order_q[scan_q[IW-1:0]] <= order_q[scan_q[IW-1:0]-IW'(1)];
            order_q[scan_q[IW-1:0]-IW'(1)] <= order_q[scan_q[IW-1:0]];
            scan_q <= scan_q - CW'(1);
          end else begin
            // insertion of current key finished; next key at j_q+2
            if (j_q + CW'(2) >= act_q) begin
              i_q <= '0; j_q <= CW'(1);
              state_q <= S_PAIR_A;
            end else begin
              j_q <= j_q + CW'(1);
              scan_q <= j_q + CW'(2);
              i_q <= CW'(1);
              state_q <= S_SORT_RD;
            end
          end
        end
        S_PAIR_A: state_q <= S_PAIR_B;
        S_PAIR_B: begin
          ea_q <= mem_rdata_i;
          state_q <= S_PAIR_WAIT;
        end
        S_PAIR_WAIT: begin
          eb_q <= mem_rdata_i;
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (skip) begin
            hit_q <= 1'b0;
            state_q <= S_EMIT;
          end else if (prune) begin
            hit_q <= 1'b0;
            j_q <= act_q;
            state_q <= S_EMIT;
          end else if (ox > 0 && oy > 0) begin
            hit_q <= 1'b1;
            if (ox < oy) begin
              pen_q <= ox[14:0]; nx_q <= dx[19] ? 2'b11 : 2'b01; ny_q <= 2'b00;
            end else begin
              pen_q <= oy[14:0]; ny_q <= dy[19] ? 2'b11 : 2'b01; nx_q <= 2'b00;
            end
            state_q <= (ea_q.is_trigger || eb_q.is_trigger) ? S_EMIT : S_PUSH_A;
          end else begin
            hit_q <= 1'b0;
            state_q <= S_EMIT;
          end
        end
        S_PUSH_A: state_q <= S_PUSH_B;
        S_PUSH_B: state_q <= S_EMIT;
        S_EMIT: if (out_free) begin
          if (hit_q && nev_q < 6'(spac_pkg::EventCap)) nev_q <= nev_q + 6'd1;
          if (j_q + CW'(1) < act_q) begin
            j_q <= j_q + CW'(1);
            state_q <= S_PAIR_A;
          end else if (i_q + CW'(2) < act_q) begin
            i_q <= i_q + CW'(1);
            j_q <= i_q + CW'(2);
            state_q <= S_PAIR_A;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/sweep_prune_aabb_collision.sv
// ----------------------------------------------------------------------------
// sweep_prune_aabb_collision: sweep-and-prune box collision block
// channel   dir  contents
// s_axis    in   command item: opcode on tuser, index and entity record on tdata
// m_axis    out  event, readback or done item: kind on tuser, last item on tlast
// cfg       in   entity_count
// Load and remove are taken while idle; a read returns a readback item. A run
// collects valid slots, insertion-sorts them by x through the single memory
// read port, then tests each pair and pushes overlapping non-trigger bodies
// apart; the done item follows. Reset clears valid bits and state.
// A stalled result holds the sequencer at its next result; while idle, new
// items are still taken with a result waiting.
// ----------------------------------------------------------------------------
module sweep_prune_aabb_collision (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entity_index[2:0] pos_x[18:3] pos_y[34:19] box_off_x[42:35]
  // box_off_y[50:43] box_width[58:51] box_height[66:59] is_static[67]
  // is_trigger[68] layer_bits[76:69] interact_bits[84:77]
  input  logic [87:0] s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // first_entity[2:0] second_entity[5:3] penetration_depth[20:6]
  // normal_x[22:21] normal_y[24:23] read_x[40:25] read_y[56:41]
  output logic [63:0] m_axis_tdata,
  // kind[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_data_i
);

  logic [3:0] count_q;
  spac_pkg::entity_t ent;
  spac_pkg::mem_req_t req;
  spac_pkg::entity_t rdata;
  spac_pkg::result_t res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= 4'(spac_pkg::MaxEntities);
    else if (cfg_valid_i && cfg_ready_o) count_q <= cfg_data_i;
  end

  assign ent = '{pos_x: s_axis_tdata[18:3], pos_y: s_axis_tdata[34:19],
                 off_x: s_axis_tdata[42:35], off_y: s_axis_tdata[50:43],
                 width: s_axis_tdata[58:51], height: s_axis_tdata[66:59],
                 is_static: s_axis_tdata[67], is_trigger: s_axis_tdata[68],
                 layer_bits: s_axis_tdata[76:69], interact_bits: s_axis_tdata[84:77]};

  spac_table u_table (.clk_i, .req_i(req), .rdata_o(rdata));

  spac_engine u_engine (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .index_i(s_axis_tdata[2:0]), .ent_i(ent),
    .count_i(count_q), .mem_o(req), .mem_rdata_i(rdata),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res.read_y, res.read_x, res.normal_y, res.normal_x,
                         res.pen, res.second_entity, res.first_entity};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_item;

`ifndef ASSERT_OFF
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tlast == (m_axis_tuser != spac_pkg::KindEvent))
    else $error("last flag does not match result kind");
`endif

endmodule
